// ===== design/cpr_pkg.sv =====
`default_nettype none
package cpr_pkg;

   localparam int unsigned MAX_LEN = 4096;
   localparam int unsigned POS_W = $clog2(MAX_LEN + 2);
   localparam int unsigned CONS_W = 13;
   localparam int unsigned COLOR_W = 24;

   localparam int unsigned SEG_HEX = 6;
   localparam int unsigned WIN_DEPTH = 14;
   localparam int unsigned FILL_W = 4;

   localparam logic [FILL_W-1:0] LEN_PLAIN = 4'd6;
   localparam logic [FILL_W-1:0] LEN_INV = 4'd7;
   localparam logic [FILL_W-1:0] LEN_RANGE = 4'd13;
   localparam logic [FILL_W-1:0] LEN_INV_RANGE = 4'd14;

   localparam logic [7:0] CH_BANG = 8'h21;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_BAR = 8'h7C;

   localparam logic KIND_ENTRY = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      PH_START,
      PH_SEP,
      PH_STOP,
      PH_FAIL
   } cpr_phase_type;

   typedef enum logic [1:0] {
      ENT_PLAIN,
      ENT_INV,
      ENT_RANGE,
      ENT_INV_RANGE
   } cpr_entry_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nib;
   } cpr_hex_type;

   // one queue slot: an optional entry and an optional end-of-string status
   typedef struct packed {
      logic                has_entry;
      cpr_entry_type       etype;
      logic [COLOR_W-1:0]  base;
      logic [COLOR_W-1:0]  shift;
      logic                has_status;
      logic                err;
      logic [CONS_W-1:0]   cons;
   } cpr_rec_type;

   function automatic cpr_hex_type hex_decode(input logic [7:0] c);
      cpr_hex_type r;
      logic [7:0]  d;
      r.ok = 1'b1;
      d = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
      end else begin
         r.ok = 1'b0;
      end
      r.nib = d[3:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== design/cpr_req_if.sv =====
`default_nettype none
interface cpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_text;

   modport source (output valid, ch, end_of_text, input ready);
   modport sink (input valid, ch, end_of_text, output ready);
endinterface
`default_nettype wire

// ===== design/cpr_rsp_if.sv =====
`default_nettype none
interface cpr_rsp_if;
   logic        valid;
   logic        ready;
   logic        item_kind;
   logic [1:0]  entry_type;
   logic [23:0] base_color;
   logic [23:0] shift_value;
   logic        parse_error;
   logic [12:0] consumed;
   logic        final_item;

   modport source (output valid, item_kind, entry_type, base_color, shift_value,
                   parse_error, consumed, final_item, input ready);
   modport sink (input valid, item_kind, entry_type, base_color, shift_value,
                 parse_error, consumed, final_item, output ready);
endinterface
`default_nettype wire

// ===== design/cpr_front.sv =====
`default_nettype none
module cpr_front (
   input wire                  clock,
   input wire                  reset,
   cpr_req_if.sink             req_if,
   output logic                push_valid,
   output cpr_pkg::cpr_rec_type push_rec,
   input wire                  queue_full
);

   logic [7:0]                      win_ff [cpr_pkg::WIN_DEPTH];
   logic [cpr_pkg::FILL_W-1:0]      fill_ff, fill_in;
   logic [cpr_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [cpr_pkg::POS_W-1:0]       cons_ff, cons_in;
   cpr_pkg::cpr_phase_type          phase_ff, phase_in;

   logic                            accept;
   logic [cpr_pkg::POS_W-1:0]       pos_inc;
   cpr_pkg::cpr_phase_type          phase_a;
   logic [7:0]                      win_a [cpr_pkg::WIN_DEPTH];
   logic [cpr_pkg::FILL_W-1:0]      fill_a;
   logic [cpr_pkg::WIN_DEPTH-1:0]   hok;
   logic [3:0]                      nib [cpr_pkg::WIN_DEPTH];
   logic [cpr_pkg::COLOR_W-1:0]     col0, col1, col7, col8;
   logic                            ok0, ok1, ok7, ok8;

   logic                            settle, short_tail, hex_ok, bang;
   cpr_pkg::cpr_entry_type          etype;
   logic [cpr_pkg::FILL_W-1:0]      seg_len;
   logic [7:0]                      sep_ch;
   logic                            emit_entry;
   logic [cpr_pkg::POS_W-1:0]       cons_adv;
   logic                            err;

   assign req_if.ready = !queue_full;
   assign accept = req_if.valid && req_if.ready;

   // window with the incoming character placed, and hex decode of each slot
   always_comb begin
      cpr_pkg::cpr_hex_type h;
      pos_inc = pos_ff;
      if (pos_ff <= cpr_pkg::POS_W'(cpr_pkg::MAX_LEN)) begin
         pos_inc = pos_ff + 1'b1;
      end
      phase_a = (pos_inc > cpr_pkg::POS_W'(cpr_pkg::MAX_LEN)) ? cpr_pkg::PH_FAIL : phase_ff;
      for (int i = 0; i < cpr_pkg::WIN_DEPTH; i++) begin
         win_a[i] = win_ff[i];
      end
      if (phase_a == cpr_pkg::PH_START && fill_ff < cpr_pkg::FILL_W'(cpr_pkg::WIN_DEPTH)) begin
         win_a[fill_ff] = req_if.ch;
      end
      fill_a = fill_ff + 1'b1;
      for (int i = 0; i < cpr_pkg::WIN_DEPTH; i++) begin
         h = cpr_pkg::hex_decode(win_a[i]);
         hok[i] = h.ok;
         nib[i] = h.nib;
      end
      for (int i = 0; i < cpr_pkg::SEG_HEX; i++) begin
         col0[cpr_pkg::COLOR_W-1-4*i -: 4] = nib[i];
         col1[cpr_pkg::COLOR_W-1-4*i -: 4] = nib[i+1];
         col7[cpr_pkg::COLOR_W-1-4*i -: 4] = nib[i+7];
         col8[cpr_pkg::COLOR_W-1-4*i -: 4] = nib[i+8];
      end
      ok0 = &hok[5:0];
      ok1 = &hok[6:1];
      ok7 = &hok[12:7];
      ok8 = &hok[13:8];
   end

   // classify the segment at the head of the window
   always_comb begin
      bang = (win_a[0] == cpr_pkg::CH_BANG);
      settle = 1'b0;
      short_tail = 1'b0;
      etype = cpr_pkg::ENT_PLAIN;
      if (bang) begin
         if (fill_a >= 4'd8 && win_a[7] != cpr_pkg::CH_DASH) begin
            settle = 1'b1;
            etype = cpr_pkg::ENT_INV;
         end else if (fill_a >= cpr_pkg::LEN_INV_RANGE) begin
            settle = 1'b1;
            etype = cpr_pkg::ENT_INV_RANGE;
         end else if (req_if.end_of_text) begin
            if (fill_a < cpr_pkg::LEN_INV) begin
               short_tail = 1'b1;
            end else begin
               settle = 1'b1;
               etype = cpr_pkg::ENT_INV;
            end
         end
      end else begin
         if (fill_a >= cpr_pkg::LEN_INV && win_a[6] != cpr_pkg::CH_DASH) begin
            settle = 1'b1;
            etype = cpr_pkg::ENT_PLAIN;
         end else if (fill_a >= cpr_pkg::LEN_RANGE) begin
            settle = 1'b1;
            etype = cpr_pkg::ENT_RANGE;
         end else if (req_if.end_of_text) begin
            if (fill_a < cpr_pkg::LEN_PLAIN) begin
               short_tail = 1'b1;
            end else begin
               settle = 1'b1;
               etype = cpr_pkg::ENT_PLAIN;
            end
         end
      end
      unique case (etype)
         cpr_pkg::ENT_PLAIN: begin
            seg_len = cpr_pkg::LEN_PLAIN;
            hex_ok = ok0;
            sep_ch = win_a[6];
         end
         cpr_pkg::ENT_INV: begin
            seg_len = cpr_pkg::LEN_INV;
            hex_ok = ok1;
            sep_ch = win_a[7];
         end
         cpr_pkg::ENT_RANGE: begin
            seg_len = cpr_pkg::LEN_RANGE;
            hex_ok = ok0 && ok7;
            sep_ch = 8'h00;
         end
         default: begin
            seg_len = cpr_pkg::LEN_INV_RANGE;
            hex_ok = ok1 && ok8;
            sep_ch = 8'h00;
         end
      endcase
      cons_adv = cons_ff + cpr_pkg::POS_W'(seg_len);
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      fill_in = fill_ff;
      pos_in = pos_ff;
      cons_in = cons_ff;
      emit_entry = 1'b0;
      if (accept) begin
         pos_in = pos_inc;
         phase_in = phase_a;
         unique case (phase_a)
            cpr_pkg::PH_SEP: begin
               if (req_if.ch == cpr_pkg::CH_BAR) begin
                  cons_in = pos_inc;
                  phase_in = cpr_pkg::PH_START;
               end else begin
                  phase_in = cpr_pkg::PH_STOP;
               end
            end
            cpr_pkg::PH_START: begin
               fill_in = fill_a;
               if (short_tail || (settle && !hex_ok)) begin
                  phase_in = cpr_pkg::PH_FAIL;
               end else if (settle) begin
                  emit_entry = 1'b1;
                  fill_in = '0;
                  cons_in = cons_adv;
                  if (fill_a == seg_len) begin
                     phase_in = cpr_pkg::PH_SEP;
                  end else if (sep_ch == cpr_pkg::CH_BAR) begin
                     cons_in = cons_adv + 1'b1;
                     phase_in = cpr_pkg::PH_START;
                  end else begin
                     phase_in = cpr_pkg::PH_STOP;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // queue record
   always_comb begin
      unique case (phase_in)
         cpr_pkg::PH_FAIL: err = 1'b1;
         cpr_pkg::PH_STOP: err = (pos_in - cons_in) < cpr_pkg::POS_W'(cpr_pkg::SEG_HEX);
         cpr_pkg::PH_SEP:  err = 1'b0;
         default:          err = (fill_in != '0);
      endcase
      push_valid = accept && (emit_entry || req_if.end_of_text);
      push_rec.has_entry = emit_entry;
      push_rec.etype = etype;
      push_rec.base = (etype == cpr_pkg::ENT_PLAIN || etype == cpr_pkg::ENT_RANGE) ? col0 : col1;
      unique case (etype)
         cpr_pkg::ENT_RANGE:     push_rec.shift = col7;
         cpr_pkg::ENT_INV_RANGE: push_rec.shift = col8;
         default:                push_rec.shift = '0;
      endcase
      push_rec.has_status = req_if.end_of_text;
      push_rec.err = err;
      push_rec.cons = cons_in[cpr_pkg::CONS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (accept && phase_a == cpr_pkg::PH_START &&
          fill_ff < cpr_pkg::FILL_W'(cpr_pkg::WIN_DEPTH)) begin
         win_ff[fill_ff] <= req_if.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= cpr_pkg::PH_START;
         fill_ff <= '0;
         pos_ff <= '0;
         cons_ff <= '0;
      end else if (accept && req_if.end_of_text) begin
         // string done: back to the start for the next one
         phase_ff <= cpr_pkg::PH_START;
         fill_ff <= '0;
         pos_ff <= '0;
         cons_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         fill_ff <= fill_in;
         pos_ff <= pos_in;
         cons_ff <= cons_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/cpr_queue.sv =====
`default_nettype none
module cpr_queue (
   input wire                    clock,
   input wire                    reset,
   input wire                    push_valid,
   input var cpr_pkg::cpr_rec_type push_rec,
   output logic                  full,
   output logic                  pop_valid,
   output cpr_pkg::cpr_rec_type  pop_rec,
   input wire                    pop_ready
);

   cpr_pkg::cpr_rec_type          mem_ff [cpr_pkg::QUEUE_DEPTH];
   logic [cpr_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [cpr_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [cpr_pkg::QPTR_W:0]      count_ff, count_in;
   logic                          do_push, do_pop;

   assign full = (count_ff == (cpr_pkg::QPTR_W+1)'(cpr_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_rec = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/cpr_back.sv =====
`default_nettype none
module cpr_back (
   input wire                    clock,
   input wire                    reset,
   input wire                    pop_valid,
   input var cpr_pkg::cpr_rec_type pop_rec,
   output logic                  pop_ready,
   cpr_rsp_if.source             rsp_if
);

   logic                          out_valid_ff, out_valid_in;
   logic                          pend_ff, pend_in;
   logic                          pend_err_ff;
   logic [cpr_pkg::CONS_W-1:0]    pend_cons_ff;
   logic                          can_load, load_pend, load_head, head_entry;

   logic                          kind_ff, kind_in;
   logic [1:0]                    type_ff, type_in;
   logic [cpr_pkg::COLOR_W-1:0]   base_ff, base_in;
   logic [cpr_pkg::COLOR_W-1:0]   shift_ff, shift_in;
   logic                          err_ff, err_in;
   logic [cpr_pkg::CONS_W-1:0]    cons_ff, cons_in;

   assign can_load = !out_valid_ff || rsp_if.ready;
   // a held status goes out before the next queue slot
   assign load_pend = can_load && pend_ff;
   assign load_head = can_load && !pend_ff && pop_valid;
   assign pop_ready = load_head;
   assign head_entry = pop_rec.has_entry;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_if.ready;
      pend_in = pend_ff;
      kind_in = kind_ff;
      type_in = type_ff;
      base_in = base_ff;
      shift_in = shift_ff;
      err_in = err_ff;
      cons_in = cons_ff;
      if (load_pend || (load_head && !head_entry)) begin
         out_valid_in = 1'b1;
         pend_in = 1'b0;
         kind_in = cpr_pkg::KIND_STATUS;
         type_in = '0;
         base_in = '0;
         shift_in = '0;
         err_in = load_pend ? pend_err_ff : pop_rec.err;
         cons_in = load_pend ? pend_cons_ff : pop_rec.cons;
      end else if (load_head) begin
         out_valid_in = 1'b1;
         pend_in = pop_rec.has_status;
         kind_in = cpr_pkg::KIND_ENTRY;
         type_in = pop_rec.etype;
         base_in = pop_rec.base;
         shift_in = pop_rec.shift;
         err_in = 1'b0;
         cons_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_head) begin
         pend_err_ff <= pop_rec.err;
         pend_cons_ff <= pop_rec.cons;
      end
      kind_ff <= kind_in;
      type_ff <= type_in;
      base_ff <= base_in;
      shift_ff <= shift_in;
      err_ff <= err_in;
      cons_ff <= cons_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff <= pend_in;
      end
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.item_kind = kind_ff;
   assign rsp_if.entry_type = type_ff;
   assign rsp_if.base_color = base_ff;
   assign rsp_if.shift_value = shift_ff;
   assign rsp_if.parse_error = err_ff;
   assign rsp_if.consumed = cons_ff;
   assign rsp_if.final_item = (kind_ff == cpr_pkg::KIND_STATUS);

endmodule
`default_nettype wire

// ===== design/color_list_text_parser.sv =====
// A result item is written to a queue slot on the edge that accepts the character
// that settles it, then moves to the output register once that register is free.
// One character per cycle while the queue is not full; the output register gives one
// item per cycle while rsp_if is ready; a final entry and its status go out in turn.
// The four-slot queue between parser and output absorbs output stalls.
// Reset (synchronous, active high) returns the parser to the start of a string
// and empties the queue and output register.
`default_nettype none
module color_list_text_parser (
   input wire          clock,
   input wire          reset,
   cpr_req_if.sink     req_if,
   cpr_rsp_if.source   rsp_if
);

   logic                  push_valid, queue_full;
   cpr_pkg::cpr_rec_type  push_rec, pop_rec;
   logic                  pop_valid, pop_ready;

   cpr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .queue_full (queue_full)
   );

   cpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_rec    (pop_rec),
      .pop_ready  (pop_ready)
   );

   cpr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_rec   (pop_rec),
      .pop_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule
`default_nettype wire
